### src/euvf_pkg.sv
// Shared types, constants and codes for the encoder unwrap and velocity filter.
package euvf_pkg;

  localparam int DT_WIDTH_DEF      = 24;
  localparam int VEL_FRAC_BITS_DEF = 12;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int OUT_W      = 88;

  localparam logic [CFG_IDX_W-1:0] CFG_CPR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 2'd3;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_SKIPPED  = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_RECOVER  = 3'd3;
  localparam logic [2:0] ST_ZEROED   = 3'd4;

  localparam logic [15:0] CPR_RESET    = 16'd4096;
  localparam logic [15:0] RAW_LIMIT    = 16'd4095;
  localparam logic [1:0]  REJECT_LIMIT = 2'd3;
  localparam logic [16:0] ALPHA_ONE    = 17'h10000;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [47:0] VEL_MAX      = 48'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic load;
    logic simple;
    logic unwrap;
    logic div_start;
    logic sat;
    logic diff;
    logic mul_hi;
    logic mul_lo;
    logic sum;
    logic ema;
    logic emit;
  } euvf_cmd_t;

  typedef struct packed {
    logic simple;
    logic div_busy;
  } euvf_sts_t;

endpackage

### src/euvf_div.sv
// Restoring divider, one quotient bit per cycle.
module euvf_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

### src/euvf_dp.sv
// Datapath: configuration, tracking state, unwrap, divider and velocity average.
module euvf_dp #(
  parameter int DT_WIDTH      = euvf_pkg::DT_WIDTH_DEF,
  parameter int VEL_FRAC_BITS = euvf_pkg::VEL_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [euvf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [euvf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [((DT_WIDTH+17+7)/8)*8-1:0]    in_tdata,
  input  euvf_pkg::euvf_cmd_t                 cmd,
  output euvf_pkg::euvf_sts_t                 sts,
  output logic [euvf_pkg::OUT_W-1:0]          out_tdata
);
  import euvf_pkg::*;

  localparam int NUM_W = 36 + VEL_FRAC_BITS;
  localparam int QX_W  = (NUM_W > 48) ? NUM_W : 48;

  // configuration
  logic [15:0] cpr_r;
  logic        range_r;
  logic [16:0] alpha_r;
  logic        invert_r;

  // tracking state
  logic [15:0] last_raw_r;
  logic [31:0] pos_r;
  logic [47:0] avg_r;
  logic [1:0]  rej_cnt_r;

  // item registers
  logic              op_r;
  logic [15:0]       raw_r;
  logic [DT_WIDTH-1:0] dt_r;
  logic [15:0]       d_r;
  logic [2:0]        status_r;
  logic [47:0]       inst_r;
  logic              dneg_r;
  logic [47:0]       mag_r;
  logic [48:0]       prod_hi_r;
  logic [16:0]       prod_lo_r;
  logic [48:0]       prod_r;

  // output payload
  logic [31:0] pos_o_r;
  logic [47:0] vel_o_r;
  logic [2:0]  st_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r    <= CPR_RESET;
      range_r  <= 1'b1;
      alpha_r  <= '0;
      invert_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CPR:    cpr_r    <= cfg_data[15:0];
        CFG_RANGE:  range_r  <= cfg_data[0];
        CFG_ALPHA:  alpha_r  <= cfg_data;
        CFG_INVERT: invert_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // classification of the held beat
  logic is_reject;
  assign is_reject  = range_r && (raw_r > RAW_LIMIT);
  assign sts.simple = op_r || (dt_r == '0) || is_reject;

  logic [1:0] rej_inc;
  assign rej_inc = rej_cnt_r + 2'd1;

  // unwrap the wrapped difference into the nearest turn
  logic [15:0] d0, d1, d2;
  logic [16:0] halfx;
  logic        gt, lt;
  always_comb begin
    halfx = {2'b00, cpr_r[15:1]};
    d0    = raw_r - last_raw_r;
    gt    = $signed({d0[15], d0}) > $signed(halfx);
    d1    = gt ? d0 - cpr_r : d0;
    lt    = $signed({d1[15], d1}) < $signed(17'd0 - halfx);
    d2    = lt ? d1 + cpr_r : d1;
  end

  // dividend: |d| * 1e6 scaled by the fraction bits
  logic [15:0]      dmag;
  logic [35:0]      dprod;
  logic [NUM_W-1:0] dividend;
  logic [NUM_W-1:0] quotient;
  assign dmag     = d_r[15] ? 16'(16'd0 - d_r) : d_r;
  assign dprod    = dmag * USEC_PER_SEC;
  assign dividend = NUM_W'(dprod) << VEL_FRAC_BITS;

  euvf_div #(
    .NUM_W (NUM_W),
    .DEN_W (DT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (dt_r),
    .busy     (sts.div_busy),
    .quotient (quotient)
  );

  // saturate quotient; the sign is applied when inst_r is registered
  logic [QX_W-1:0] q_ext;
  logic [47:0]     q_sat;
  assign q_ext = QX_W'(quotient);
  assign q_sat = (q_ext > QX_W'(VEL_MAX)) ? VEL_MAX : q_ext[47:0];

  // difference to the running average
  logic [48:0] diff;
  assign diff = {inst_r[47], inst_r} - {avg_r[47], avg_r};

  // shared 17x32 multiplier for the two halves of the blend product
  logic [16:0] alpha_c;
  logic [31:0] mul_b;
  logic [48:0] mul_p;
  assign alpha_c = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign mul_b   = cmd.mul_lo ? {16'd0, mag_r[15:0]} : mag_r[47:16];
  assign mul_p   = alpha_c * mul_b;

  logic [48:0] avg_sum;
  assign avg_sum = dneg_r ? ({avg_r[47], avg_r} - prod_r) : ({avg_r[47], avg_r} + prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= '0;
      pos_r      <= '0;
      avg_r      <= '0;
      rej_cnt_r  <= '0;
    end else if (cmd.simple) begin
      if (op_r) begin
        last_raw_r <= raw_r;
        pos_r      <= '0;
        avg_r      <= '0;
      end else if ((dt_r != '0) && (rej_inc >= REJECT_LIMIT)) begin
        rej_cnt_r <= '0;
      end else if (dt_r != '0) begin
        rej_cnt_r <= rej_inc;
      end
    end else if (cmd.unwrap) begin
      last_raw_r <= raw_r;
      pos_r      <= pos_r + {{16{d2[15]}}, d2};
      rej_cnt_r  <= '0;
    end else if (cmd.ema) begin
      avg_r <= avg_sum[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_tdata[0];
      raw_r <= in_tdata[16:1];
      dt_r  <= in_tdata[DT_WIDTH+16:17];
    end
    if (cmd.simple) begin
      if (op_r) begin
        status_r <= ST_ZEROED;
      end else if (dt_r == '0) begin
        status_r <= ST_SKIPPED;
      end else if (rej_inc >= REJECT_LIMIT) begin
        status_r <= ST_RECOVER;
      end else begin
        status_r <= ST_REJECTED;
      end
    end
    if (cmd.unwrap) begin
      d_r      <= d2;
      status_r <= ST_UPDATED;
    end
    if (cmd.sat) begin
      inst_r <= d_r[15] ? 48'(48'd0 - q_sat) : q_sat;
    end
    if (cmd.diff) begin
      dneg_r <= diff[48];
      mag_r  <= diff[48] ? 48'(49'd0 - diff) : diff[47:0];
    end
    if (cmd.mul_hi) begin
      prod_hi_r <= mul_p;
    end
    if (cmd.mul_lo) begin
      prod_lo_r <= mul_p[32:16];
    end
    if (cmd.sum) begin
      prod_r <= prod_hi_r + {32'd0, prod_lo_r};
    end
    if (cmd.emit) begin
      pos_o_r <= invert_r ? 32'(32'd0 - pos_r) : pos_r;
      vel_o_r <= invert_r ? 48'(48'd0 - avg_r) : avg_r;
      st_o_r  <= status_r;
    end
  end

  assign out_tdata = {5'd0, st_o_r, vel_o_r, pos_o_r};

endmodule

### src/euvf_ctrl.sv
// Controller: one beat through decode, divide and blend if needed, output.
module euvf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  euvf_pkg::euvf_sts_t  sts,
  output euvf_pkg::euvf_cmd_t  cmd
);
  import euvf_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_DIV_GO = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_DIFF   = 4'd4;
  localparam logic [3:0] S_MUL_HI = 4'd5;
  localparam logic [3:0] S_MUL_LO = 4'd6;
  localparam logic [3:0] S_SUM    = 4'd7;
  localparam logic [3:0] S_EMA    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_free   = !ovalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.simple) begin
          cmd.simple = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          cmd.unwrap = 1'b1;
          state_nxt  = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        // hold until the last quotient bit is in
        if (!sts.div_busy) begin
          cmd.sat   = 1'b1;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_EMA;
      end
      S_EMA: begin
        cmd.ema   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

### src/encoder_unwrap_velocity_filter.sv
// Top level of the multi-turn encoder unwrap with filtered velocity.
// Each input beat is taken while the block is idle and yields exactly one output beat.
// A zero calibration, a skipped beat (dt_us of zero) or a rejected reading goes
// from decode straight to the result register. A normal sample runs through
// decode, the restoring divider that forms |d| * 1e6 * 2^VEL_FRAC_BITS / dt_us
// one quotient bit per cycle, the two halves of the alpha blend on one shared
// multiplier and the average update. The next beat is accepted while a finished
// result still waits in the output register. Write configuration only while idle.
module encoder_unwrap_velocity_filter #(
  parameter int DT_WIDTH      = euvf_pkg::DT_WIDTH_DEF,
  parameter int VEL_FRAC_BITS = euvf_pkg::VEL_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [euvf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [euvf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // op [0], raw_angle [16:1], dt_us [DT_WIDTH+16:17], zero padding above
  input  logic [((DT_WIDTH+17+7)/8)*8-1:0]   in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // position_counts [31:0], velocity_cps [79:32], status [82:80], zero padding above
  output logic [euvf_pkg::OUT_W-1:0]         out_tdata
);
  import euvf_pkg::*;

  euvf_cmd_t cmd;
  euvf_sts_t sts;

  euvf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  euvf_dp #(
    .DT_WIDTH      (DT_WIDTH),
    .VEL_FRAC_BITS (VEL_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

### src/euvf_checker.sv
// Port-level checks for the encoder unwrap block, bound to the top level.
module euvf_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [euvf_pkg::OUT_W-1:0] out_tdata
);
  import euvf_pkg::*;

  logic [2:0]  st;
  logic [31:0] pos;
  logic [47:0] vel;
  assign pos = out_tdata[31:0];
  assign vel = out_tdata[79:32];
  assign st  = out_tdata[82:80];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  // one beat in flight: no acceptance right after an acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while previous beat still in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> st <= ST_ZEROED)
    else $error("status code out of range");

  a_zeroed_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st == ST_ZEROED) |-> (pos == 32'd0) && (vel == 48'd0))
    else $error("zero calibration did not clear position and velocity");

  a_vel_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> vel != 48'h8000_0000_0000)
    else $error("velocity reached the negative limit");

endmodule

bind encoder_unwrap_velocity_filter euvf_checker u_euvf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
